/* hdl/fftrim_pkg.sv */
`default_nettype none

package fftrim_pkg;

   // Geometry of the vector unit and the memory system.
   localparam int VLEN_BYTES = 16;
   localparam int PAGE_BYTES = 4096;
   localparam int MAX_MICRO  = 8;

   // Largest vector length the block reports.
   localparam int LEN_CAP = 128;

   // Field widths of the transfer on both channels.
   localparam int NUM_LANES = 8;
   localparam int COUNT_W   = 5;
   localparam int MICRO_W   = 4;
   localparam int OFF_W     = 12;
   localparam int LEN_W     = 8;
   localparam int WCODE_W   = 3;

   // Width codes below this one name an element size; the rest mean no trim.
   localparam logic [WCODE_W-1:0] WCODE_LIMIT = WCODE_W'(4);

   // Derived widths.
   localparam int PAGE_W  = $clog2(PAGE_BYTES);
   localparam int VLEN_W  = $clog2(VLEN_BYTES);
   localparam int FULL_W  = VLEN_W + 1;
   localparam int SUM_W   = COUNT_W + $clog2(NUM_LANES);
   localparam int TOT_W   = (SUM_W > LEN_W) ? SUM_W : LEN_W;
   localparam int FULLC_W = (COUNT_W > FULL_W) ? COUNT_W : FULL_W;
   localparam int FITC_W  = (COUNT_W > VLEN_W) ? COUNT_W : VLEN_W;
   localparam int SHIFT_W = 2;

   typedef logic [COUNT_W-1:0]                  count_type;
   typedef count_type [NUM_LANES-1:0]           count_vec_type;
   typedef logic [VLEN_W-1:0]                   room_type;
   typedef room_type [NUM_LANES-1:0]            room_vec_type;

   // Result of the first stage: the sum and the per-lane boundary candidates.
   typedef struct packed {
      logic [TOT_W-1:0]    total;
      logic [LEN_W-1:0]    req_cap;
      logic                width_ok;
      logic [SHIFT_W-1:0]  shift;
      logic [NUM_LANES-1:0] hit;
      count_vec_type       prev;
      room_vec_type        room;
   } front_type;

   // Result of the second stage: the selected trim and whether it applies.
   typedef struct packed {
      logic [TOT_W-1:0]    total;
      logic                trim_en;
      count_type           amount;
   } pick_type;

endpackage

`default_nettype wire

/* hdl/fault_first_vl_trim_core.sv */
`default_nettype none

// Final vector length after a fault-only-first load split into micro-ops.
// Each request transfer carries the per-micro-op element counts, the number
// of micro-ops in use, the page offset of the base address, the requested
// length and the element width code; each response transfer carries the
// trimmed length. The block has no state between items. It is a three-stage
// pipeline (sum and boundary flags, priority pick, trim and cap). A request
// passes the front, pick and finish registers in turn; the finish register
// drives the response. One request can be taken in every cycle while the
// response side does not stall. A stall on the response side holds every
// stage with no free slot behind it, and the request stall follows it in the same cycle.
module fault_first_vl_trim_core
   import fftrim_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COUNT_W-1:0]  req_count_0,
   input  wire logic [COUNT_W-1:0]  req_count_1,
   input  wire logic [COUNT_W-1:0]  req_count_2,
   input  wire logic [COUNT_W-1:0]  req_count_3,
   input  wire logic [COUNT_W-1:0]  req_count_4,
   input  wire logic [COUNT_W-1:0]  req_count_5,
   input  wire logic [COUNT_W-1:0]  req_count_6,
   input  wire logic [COUNT_W-1:0]  req_count_7,
   input  wire logic [MICRO_W-1:0]  req_micro_count,
   input  wire logic [OFF_W-1:0]    req_base_offset,
   input  wire logic [LEN_W-1:0]    req_requested_len,
   input  wire logic [WCODE_W-1:0]  req_width_code,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [LEN_W-1:0]         rsp_new_len
);

   count_vec_type  counts;
   logic           front_valid;
   front_type      front_data;
   logic           pick_valid;
   pick_type       pick_data;
   logic           front_load;
   logic           pick_load;
   logic           finish_load;

   assign counts = {req_count_7, req_count_6, req_count_5, req_count_4,
                    req_count_3, req_count_2, req_count_1, req_count_0};

   // A stage loads when it is empty or its content moves on this cycle.
   assign finish_load = !rsp_valid || !rsp_stall;
   assign pick_load   = !pick_valid || finish_load;
   assign front_load  = !front_valid || pick_load;
   assign req_stall   = !front_load;

   fftrim_front u_front (
      .clock            (clock),
      .reset            (reset),
      .load             (front_load),
      .in_valid         (req_valid),
      .in_count         (counts),
      .in_micro_count   (req_micro_count),
      .in_base_offset   (req_base_offset),
      .in_requested_len (req_requested_len),
      .in_width_code    (req_width_code),
      .out_valid        (front_valid),
      .out_data         (front_data)
   );

   fftrim_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .load      (pick_load),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (pick_valid),
      .out_data  (pick_data)
   );

   fftrim_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .load        (finish_load),
      .in_valid    (pick_valid),
      .in_data     (pick_data),
      .out_valid   (rsp_valid),
      .out_new_len (rsp_new_len)
   );

endmodule

`default_nettype wire

/* hdl/fftrim_front.sv */
`default_nettype none

module fftrim_front
   import fftrim_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic                in_valid,
   input  wire count_vec_type       in_count,
   input  wire logic [MICRO_W-1:0]  in_micro_count,
   input  wire logic [OFF_W-1:0]    in_base_offset,
   input  wire logic [LEN_W-1:0]    in_requested_len,
   input  wire logic [WCODE_W-1:0]  in_width_code,
   output logic                     out_valid,
   output front_type                out_data
);

   logic                 valid_ff;
   front_type            data_ff;
   front_type            data_in;
   logic [MICRO_W-1:0]   used;
   logic [FULL_W-1:0]    full;
   logic [PAGE_W-1:0]    addr [NUM_LANES];
   logic [PAGE_W:0]      room [NUM_LANES];

   // Clamp the controls, sum the counts in use and flag every lane that
   // is empty behind a full predecessor whose range runs past a page end.
   always_comb begin
      used = (in_micro_count > MICRO_W'(MAX_MICRO)) ? MICRO_W'(MAX_MICRO) : in_micro_count;
      full = FULL_W'(VLEN_BYTES) >> in_width_code[SHIFT_W-1:0];

      data_in.req_cap  = (in_requested_len > LEN_W'(LEN_CAP)) ?
                         LEN_W'(LEN_CAP) : in_requested_len;
      data_in.width_ok = in_width_code < WCODE_LIMIT;
      data_in.shift    = in_width_code[SHIFT_W-1:0];

      data_in.total = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (MICRO_W'(i) < used) begin
            data_in.total = data_in.total + TOT_W'(in_count[i]);
         end
      end

      addr[0]         = '0;
      room[0]         = '0;
      data_in.hit[0]  = 1'b0;
      data_in.prev[0] = '0;
      data_in.room[0] = '0;
      for (int i = 1; i < NUM_LANES; i++) begin
         addr[i] = PAGE_W'(in_base_offset) + PAGE_W'((i - 1) * VLEN_BYTES);
         room[i] = (PAGE_W + 1)'(PAGE_BYTES) - {1'b0, addr[i]};
         data_in.hit[i] = (MICRO_W'(i) < used) &&
                          (in_count[i] == '0) &&
                          (FULLC_W'(in_count[i-1]) == FULLC_W'(full)) &&
                          (room[i] < (PAGE_W + 1)'(VLEN_BYTES));
         data_in.prev[i] = in_count[i-1];
         data_in.room[i] = room[i][VLEN_W-1:0];
      end
   end

   // Stage register; it moves only when the next stage can take it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hdl/fftrim_pick.sv */
`default_nettype none

module fftrim_pick
   import fftrim_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire logic       in_valid,
   input  wire front_type  in_data,
   output logic            out_valid,
   output pick_type        out_data
);

   logic             valid_ff;
   pick_type         data_ff;
   pick_type         data_in;
   logic             found;
   count_type        sel_prev;
   room_type         sel_room;
   room_type         fit;
   logic             trim_ok;
   logic             below;

   // Take the lowest flagged lane and work out how many of its
   // predecessor's elements lie past the page boundary.
   always_comb begin
      found    = 1'b0;
      sel_prev = '0;
      sel_room = '0;
      for (int i = NUM_LANES - 1; i >= 1; i--) begin
         if (in_data.hit[i]) begin
            found    = 1'b1;
            sel_prev = in_data.prev[i];
            sel_room = in_data.room[i];
         end
      end

      fit     = sel_room >> in_data.shift;
      trim_ok = (fit != '0) && (FITC_W'(fit) < FITC_W'(sel_prev));
      below   = in_data.total < TOT_W'(in_data.req_cap);

      data_in.total   = in_data.total;
      data_in.trim_en = in_data.width_ok && below && found && trim_ok;
      data_in.amount  = sel_prev - COUNT_W'(fit);
   end

   // Stage register; it moves only when the next stage can take it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hdl/fftrim_finish.sv */
`default_nettype none

module fftrim_finish
   import fftrim_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic              in_valid,
   input  wire pick_type          in_data,
   output logic                   out_valid,
   output logic [LEN_W-1:0]       out_new_len
);

   logic               valid_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic [TOT_W-1:0]   trimmed;

   // Remove the elements past the boundary and cap the length.
   always_comb begin
      trimmed = in_data.total;
      if (in_data.trim_en && (in_data.total >= TOT_W'(in_data.amount))) begin
         trimmed = in_data.total - TOT_W'(in_data.amount);
      end
      len_in = (trimmed > TOT_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : trimmed[LEN_W-1:0];
   end

   // Output register; it holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         len_ff <= len_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_new_len = len_ff;

endmodule

`default_nettype wire
